FILE: rtl/sonar_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// Sonar frame parser assertion macros
// Shared concurrent-assertion helpers, clocked on clk_i, gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef SONAR_FRAME_PARSER_DEFINES_SVH
`define SONAR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication check
`define SFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define SFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sonar frame parser package
// Field widths, frame constants and the queue entry type.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HEIGHT_W = 23;
  localparam int unsigned CONF_W   = 16;
  localparam int unsigned DIST_W   = 32;

  // Header bytes
  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h42;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h52;

  // Payload byte positions of the distance and confidence fields
  localparam int unsigned DIST_FIRST = 6;
  localparam int unsigned DIST_LAST  = 9;
  localparam int unsigned CONF_FIRST = 10;
  localparam int unsigned CONF_LAST  = 11;

  // Divide by 1000: q = (n * ceil(2^38 / 1000)) >> 38, exact for any 32-bit n
  localparam logic [DIST_W-1:0] DIV_MAGIC = 32'd274877907;
  localparam int unsigned       DIV_SHIFT = 38;
  localparam int unsigned       PROD_W    = 2 * DIST_W;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  // One checked frame, raw fields
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [CONF_W-1:0] conf;
  } meas_t;

endpackage

FILE: rtl/sfp_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sonar byte channel
// Valid/ready channel carrying one received serial byte per beat.
// ----------------------------------------------------------------------------
interface sfp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [sfp_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/sfp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sonar result channel
// Valid/ready channel carrying one height/confidence pair per beat.
// ----------------------------------------------------------------------------
interface sfp_result_if;
  logic                          valid;
  logic                          ready;
  logic [sfp_pkg::HEIGHT_W-1:0]  height;
  logic [sfp_pkg::CONF_W-1:0]    confidence;

  modport source (output valid, output height, output confidence, input ready);
  modport sink   (input valid, input height, input confidence, output ready);
endinterface

FILE: rtl/sonar_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sonar frame parser
// Byte-serial parser for 0x42 0x52 framed sonar packets with an 8-bit sum.
// ----------------------------------------------------------------------------
// Accepts one received byte per clock while ready is high. The front
// parser takes a byte every cycle and stalls only on a checksum byte
// while its two-entry frame queue is full; a good frame yields one
// height/confidence result through the queue, one registered 32x32
// reciprocal multiply for the divide by 1000, and the output register,
// which hold it while the result channel is not ready. Bad frames are
// dropped without a result. PAYLOAD_BYTES sets the payload length.
// ----------------------------------------------------------------------------
module sonar_frame_parser #(
  parameter int unsigned PAYLOAD_BYTES = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfp_byte_if.sink     rx_i,
  sfp_result_if.source res_o
);

  logic           q_push, q_full, q_pop, q_empty;
  sfp_pkg::meas_t q_wdata, q_rdata;

  // Parse and check frames
  sfp_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // Decouple front and back
  sfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  // Scale and deliver results
  sfp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

FILE: rtl/sfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sonar frame queue
// Two-entry queue of checked frames between the parser front and the back.
// ----------------------------------------------------------------------------
`include "sonar_frame_parser_defines.svh"

module sfp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfp_pkg::meas_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sfp_pkg::meas_t pop_data_o
);

  sfp_pkg::meas_t                          mem_q [sfp_pkg::QUEUE_DEPTH];
  logic [sfp_pkg::QUEUE_PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [sfp_pkg::QUEUE_CNT_W-1:0]         cnt_q, cnt_d;

  assign full_o     = (cnt_q == sfp_pkg::QUEUE_CNT_W'(sfp_pkg::QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Track occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + sfp_pkg::QUEUE_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - sfp_pkg::QUEUE_CNT_W'(1);
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + sfp_pkg::QUEUE_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + sfp_pkg::QUEUE_PTR_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `SFP_ASSERT_IMP(a_no_overflow, push_i, !full_o, "queue push while full")
  `SFP_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "queue pop while empty")

endmodule

FILE: rtl/sfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sonar frame parser front
// Hunts for the header, collects the payload fields, checks the sum and
// pushes each good frame into the queue.
// ----------------------------------------------------------------------------
`include "sonar_frame_parser_defines.svh"

module sfp_front #(
  parameter int unsigned PAYLOAD_BYTES = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sfp_byte_if.sink                   rx_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output sfp_pkg::meas_t             q_data_o
);

  localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_CHECK = 2'd3;

  logic [1:0]                       phase_q, phase_d;
  logic [IDX_W-1:0]                 idx_q, idx_d, idx_inc;
  logic [sfp_pkg::BYTE_W-1:0]       sum_q, sum_d;
  logic [sfp_pkg::DIST_W-1:0]       dist_q;
  logic [sfp_pkg::CONF_W-1:0]       conf_q;
  logic                             beat;
  logic [sfp_pkg::BYTE_W-1:0]       b;
  logic                             in_dist, in_conf;

  // Stall only a checksum beat that finds the queue full
  assign rx_i.ready = (phase_q != PH_CHECK) || !q_full_i;
  assign beat       = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign idx_inc    = idx_q + IDX_W'(1);

  assign in_dist = (idx_q >= IDX_W'(sfp_pkg::DIST_FIRST)) &&
                   (idx_q <= IDX_W'(sfp_pkg::DIST_LAST));
  assign in_conf = (idx_q >= IDX_W'(sfp_pkg::CONF_FIRST)) &&
                   (idx_q <= IDX_W'(sfp_pkg::CONF_LAST));

  // Push a frame whose checksum byte matches
  assign q_push_o          = beat && (phase_q == PH_CHECK) && (b == sum_q);
  assign q_data_o.distance = dist_q;
  assign q_data_o.conf     = conf_q;

  // Frame sequencing
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    if (beat) begin
      case (phase_q)
        PH_HUNT1: begin
          if (b == sfp_pkg::HDR_FIRST) begin
            sum_d   = b;
            phase_d = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          if (b == sfp_pkg::HDR_SECOND) begin
            sum_d   = sum_q + b;
            idx_d   = '0;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          sum_d = sum_q + b;
          idx_d = idx_inc;
          if (idx_inc >= IDX_W'(PAYLOAD_BYTES)) begin
            phase_d = PH_CHECK;
          end
        end
        default: begin
          phase_d = PH_HUNT1;
          idx_d   = '0;
          sum_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      idx_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
    end
  end

  // Shift in the big-endian distance and confidence bytes
  always_ff @(posedge clk_i) begin
    if (beat && (phase_q == PH_DATA) && in_dist) begin
      dist_q <= {dist_q[sfp_pkg::DIST_W-sfp_pkg::BYTE_W-1:0], b};
    end
    if (beat && (phase_q == PH_DATA) && in_conf) begin
      conf_q <= {conf_q[sfp_pkg::CONF_W-sfp_pkg::BYTE_W-1:0], b};
    end
  end

  `SFP_ASSERT_IMP(a_check_idx, phase_q == PH_CHECK, idx_q == IDX_W'(PAYLOAD_BYTES),
    "checksum phase with short payload count")
  `SFP_ASSERT_IMP(a_hunt_idx, (phase_q == PH_HUNT1) || (phase_q == PH_HUNT2),
    idx_q == '0, "payload count not cleared while hunting")
  `SFP_ASSERT_NXT(a_push_rehunt, q_push_o, phase_q == PH_HUNT1,
    "parser did not return to hunting after a good frame")

endmodule

FILE: rtl/sfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sonar frame parser back
// Pops checked frames, scales the distance by 1/1000 with a reciprocal
// multiply, and holds each result in an output register.
// ----------------------------------------------------------------------------
`include "sonar_frame_parser_defines.svh"

module sfp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  sfp_pkg::meas_t       q_data_i,
  output logic                 q_pop_o,
  sfp_result_if.source         res_o
);

  logic                               mul_v_q;
  logic [sfp_pkg::PROD_W-1:0]         prod_q;
  logic [sfp_pkg::CONF_W-1:0]         mul_conf_q;
  logic                               out_v_q;
  logic [sfp_pkg::HEIGHT_W-1:0]       height_q;
  logic [sfp_pkg::CONF_W-1:0]         conf_q;
  logic                               out_load, mul_load;

  assign out_load = !out_v_q || res_o.ready;
  assign mul_load = !mul_v_q || out_load;
  assign q_pop_o  = !q_empty_i && mul_load;

  // Multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else if (mul_load) begin
      mul_v_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      prod_q     <= sfp_pkg::PROD_W'(q_data_i.distance) *
                    sfp_pkg::PROD_W'(sfp_pkg::DIV_MAGIC);
      mul_conf_q <= q_data_i.conf;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && mul_v_q) begin
      height_q <= prod_q[sfp_pkg::DIV_SHIFT +: sfp_pkg::HEIGHT_W];
      conf_q   <= mul_conf_q;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.height     = height_q;
  assign res_o.confidence = conf_q;

  `SFP_ASSERT_NXT(a_mul_hold, mul_v_q && !out_load, mul_v_q,
    "multiply stage lost a frame while stalled")

endmodule
